// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, sampled on the rising clock edge
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// implication that is also checked while reset is high
`define ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("assertion failed: implication checked through reset");

`endif

// ===== rtl/fcr_pkg.sv =====
package fcr_pkg;

   // frame sizing and timer defaults
   localparam int          FRAME_CAPACITY = 150;
   localparam logic [15:0] TIMEOUT_RESET  = 16'd250;
   localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;

   // crc-8, msb first, init 0, no final xor
   localparam logic [7:0] CRC_POLY = 8'h07;

   // item kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // framing and number characters
   localparam logic [7:0] CHAR_OPEN  = 8'h3C;
   localparam logic [7:0] CHAR_CLOSE = 8'h3E;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_COMMA = 2'd1,
      STATUS_EMPTY    = 2'd2,
      STATUS_MISMATCH = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PHASE_SKIP   = 2'd0,
      PHASE_DIGITS = 2'd1,
      PHASE_DONE   = 2'd3
   } phase_type;

   // one byte through the crc register, one bit per step
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   // white space as skipped ahead of a number
   function automatic logic is_space(input logic [7:0] data);
      return (data == CHAR_SPACE) || (data >= CHAR_TAB && data <= CHAR_CR);
   endfunction

endpackage

// ===== rtl/fcr_req_if.sv =====
interface fcr_req_if;
   import fcr_pkg::*;

   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] rx_byte;

   modport source (output valid, output kind, output rx_byte, input ready);
   modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

// ===== rtl/fcr_rsp_if.sv =====
interface fcr_rsp_if;
   import fcr_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   logic [7:0] command_byte;
   logic [7:0] data_length;
   logic [7:0] decoded_checksum;
   logic [7:0] computed_checksum;

   modport source (
      output valid, output status, output command_byte, output data_length,
      output decoded_checksum, output computed_checksum, input ready
   );
   modport sink (
      input valid, input status, input command_byte, input data_length,
      input decoded_checksum, input computed_checksum, output ready
   );
endinterface

// ===== rtl/framed_command_receiver_crc8_core.sv =====
// Framed command receiver with CRC-8 check. Each req transfer carries either a received
// byte or a one millisecond tick; '<' opens (or restarts) a frame, '>' closes it and puts
// one rsp transfer out with the status, the first body byte, the length before the last
// comma, the decimal checksum that follows it and the CRC-8 (poly 0x07) of those bytes.
// A body that outgrows the frame capacity or a timeout (csr timeout_ms, in ticks) drops
// a frame with no response. The input register takes the closing byte, and once the
// response register can take a result the crc and decimal logic fold it into the frame
// state and load the response register, whose valid bit drives rsp valid. One item is
// taken every cycle as long as the response register is empty or being drained. The user
// must write timeout_ms only while no item is in flight; the block does not enforce this.
module framed_command_receiver_crc8_core #(
   parameter int FrameCapacity = fcr_pkg::FRAME_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   fcr_req_if.sink     req_if,
   fcr_rsp_if.source   rsp_if,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   import fcr_pkg::*;

   localparam int             LEN_W    = $clog2(FrameCapacity);
   localparam logic [LEN_W-1:0] LAST_POS = LEN_W'(FrameCapacity - 1);

   // configuration
   logic [15:0] timeout_ms_ff;

   // input stage
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_kind_ff;
   logic [7:0] s1_byte_ff;

   // frame state
   logic             in_frame_ff, in_frame_in;
   logic [LEN_W-1:0] body_length_ff, body_length_in;
   logic [7:0]       running_crc_ff, running_crc_in;
   logic [7:0]       crc_before_comma_ff, crc_before_comma_in;
   logic [LEN_W-1:0] comma_position_ff, comma_position_in;
   logic             comma_seen_ff, comma_seen_in;
   logic [7:0]       number_value_ff, number_value_in;
   phase_type        number_phase_ff, number_phase_in;
   logic             number_negative_ff, number_negative_in;
   logic [7:0]       first_byte_ff, first_byte_in;
   logic [15:0]      elapsed_ms_ff, elapsed_ms_in;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [7:0] rsp_command_ff, rsp_command_in;
   logic [7:0] rsp_length_ff, rsp_length_in;
   logic [7:0] rsp_received_ff, rsp_received_in;
   logic [7:0] rsp_computed_ff, rsp_computed_in;

   logic       advance;
   logic       fire;
   logic       is_tick;
   logic       frame_live;
   logic       is_digit;
   logic [7:0] digit_value;
   logic [7:0] signed_value;

   // handshake: the input stage moves whenever the response register can take a result
   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign fire         = s1_valid_ff && advance;
   assign req_if.ready = !s1_valid_ff || advance;
   assign s1_valid_in  = req_if.ready ? req_if.valid : s1_valid_ff;

   // helper decodes of the registered byte
   assign is_tick      = (s1_kind_ff == KIND_TICK);
   assign is_digit     = (s1_byte_ff >= CHAR_ZERO) && (s1_byte_ff <= CHAR_NINE);
   assign digit_value  = s1_byte_ff - CHAR_ZERO;
   assign signed_value = number_negative_ff ? (8'd0 - number_value_ff) : number_value_ff;

   // frame state update for one item
   always_comb begin
      in_frame_in         = in_frame_ff;
      body_length_in      = body_length_ff;
      running_crc_in      = running_crc_ff;
      crc_before_comma_in = crc_before_comma_ff;
      comma_position_in   = comma_position_ff;
      comma_seen_in       = comma_seen_ff;
      number_value_in     = number_value_ff;
      number_phase_in     = number_phase_ff;
      number_negative_in  = number_negative_ff;
      first_byte_in       = first_byte_ff;
      elapsed_ms_in       = elapsed_ms_ff;
      frame_live          = in_frame_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in       = rsp_status_ff;
      rsp_command_in      = rsp_command_ff;
      rsp_length_in       = rsp_length_ff;
      rsp_received_in     = rsp_received_ff;
      rsp_computed_in     = rsp_computed_ff;

      if (fire) begin
         // tick counting and timeout drop come before byte handling
         if (is_tick && in_frame_ff && elapsed_ms_ff != ELAPSED_MAX) begin
            elapsed_ms_in = elapsed_ms_ff + 16'd1;
         end
         if (in_frame_ff && elapsed_ms_in > timeout_ms_ff) begin
            frame_live     = 1'b0;
            in_frame_in    = 1'b0;
            body_length_in = '0;
         end

         if (!is_tick) begin
            if (s1_byte_ff == CHAR_OPEN) begin
               // open or restart a frame
               in_frame_in         = 1'b1;
               body_length_in      = '0;
               running_crc_in      = 8'd0;
               crc_before_comma_in = 8'd0;
               comma_position_in   = '0;
               comma_seen_in       = 1'b0;
               number_value_in     = 8'd0;
               number_phase_in     = PHASE_SKIP;
               number_negative_in  = 1'b0;
               first_byte_in       = 8'd0;
               elapsed_ms_in       = 16'd0;
            end else if (s1_byte_ff == CHAR_CLOSE) begin
               // close and report
               if (frame_live) begin
                  in_frame_in    = 1'b0;
                  rsp_valid_in   = 1'b1;
                  rsp_command_in = first_byte_ff;
                  if (!comma_seen_ff) begin
                     rsp_status_in   = STATUS_NO_COMMA;
                     rsp_length_in   = 8'd0;
                     rsp_received_in = 8'd0;
                     rsp_computed_in = 8'd0;
                  end else begin
                     rsp_length_in   = 8'(comma_position_ff);
                     rsp_received_in = signed_value;
                     rsp_computed_in = crc_before_comma_ff;
                     if (comma_position_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else if (signed_value != crc_before_comma_ff) begin
                        rsp_status_in = STATUS_MISMATCH;
                     end else begin
                        rsp_status_in = STATUS_OK;
                     end
                  end
               end
            end else if (frame_live) begin
               if (body_length_ff >= LAST_POS) begin
                  // overflow drops the frame and the byte
                  in_frame_in    = 1'b0;
                  body_length_in = '0;
               end else begin
                  if (body_length_ff == '0) begin
                     first_byte_in = s1_byte_ff;
                  end
                  if (s1_byte_ff == CHAR_COMMA) begin
                     crc_before_comma_in = running_crc_ff;
                     comma_position_in   = body_length_ff;
                     comma_seen_in       = 1'b1;
                     number_value_in     = 8'd0;
                     number_phase_in     = PHASE_SKIP;
                     number_negative_in  = 1'b0;
                  end else if (comma_seen_ff) begin
                     // decimal decode after the comma
                     if (number_phase_ff == PHASE_SKIP && is_space(s1_byte_ff)) begin
                        number_phase_in = PHASE_SKIP;
                     end else if (number_phase_ff == PHASE_SKIP &&
                                  (s1_byte_ff == CHAR_PLUS || s1_byte_ff == CHAR_MINUS)) begin
                        number_negative_in = (s1_byte_ff == CHAR_MINUS);
                        number_phase_in    = PHASE_DIGITS;
                     end else if (number_phase_ff != PHASE_DONE && is_digit) begin
                        number_value_in = {number_value_ff[4:0], 3'b000}
                                        + {number_value_ff[6:0], 1'b0} + digit_value;
                        number_phase_in = PHASE_DIGITS;
                     end else begin
                        number_phase_in = PHASE_DONE;
                     end
                  end
                  running_crc_in = crc8_update(running_crc_ff, s1_byte_ff);
                  body_length_in = body_length_ff + LEN_W'(1);
               end
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ms_ff       <= TIMEOUT_RESET;
         s1_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         in_frame_ff         <= 1'b0;
         body_length_ff      <= '0;
         running_crc_ff      <= 8'd0;
         crc_before_comma_ff <= 8'd0;
         comma_position_ff   <= '0;
         comma_seen_ff       <= 1'b0;
         number_value_ff     <= 8'd0;
         number_phase_ff     <= PHASE_SKIP;
         number_negative_ff  <= 1'b0;
         first_byte_ff       <= 8'd0;
         elapsed_ms_ff       <= 16'd0;
      end else begin
         if (csr_write_enable) begin
            timeout_ms_ff <= csr_write_data;
         end
         s1_valid_ff         <= s1_valid_in;
         rsp_valid_ff        <= rsp_valid_in;
         in_frame_ff         <= in_frame_in;
         body_length_ff      <= body_length_in;
         running_crc_ff      <= running_crc_in;
         crc_before_comma_ff <= crc_before_comma_in;
         comma_position_ff   <= comma_position_in;
         comma_seen_ff       <= comma_seen_in;
         number_value_ff     <= number_value_in;
         number_phase_ff     <= number_phase_in;
         number_negative_ff  <= number_negative_in;
         first_byte_ff       <= first_byte_in;
         elapsed_ms_ff       <= elapsed_ms_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_if.ready) begin
         s1_kind_ff <= req_if.kind;
         s1_byte_ff <= req_if.rx_byte;
      end
      rsp_status_ff   <= rsp_status_in;
      rsp_command_ff  <= rsp_command_in;
      rsp_length_ff   <= rsp_length_in;
      rsp_received_ff <= rsp_received_in;
      rsp_computed_ff <= rsp_computed_in;
   end

   // response outputs
   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.status            = rsp_status_ff;
   assign rsp_if.command_byte      = rsp_command_ff;
   assign rsp_if.data_length       = rsp_length_ff;
   assign rsp_if.decoded_checksum  = rsp_received_ff;
   assign rsp_if.computed_checksum = rsp_computed_ff;

endmodule

// ===== rtl/fcr_checker.sv =====
`include "assert_macros.svh"

module fcr_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input fcr_pkg::status_type rsp_status,
   input logic [7:0]          rsp_data_length,
   input logic [7:0]          rsp_decoded_checksum,
   input logic [7:0]          rsp_computed_checksum
);
   import fcr_pkg::*;

   logic        rsp_stall;
   logic [25:0] rsp_fields;
   logic        figures_zero;
   logic        sums_equal;
   logic        length_set;

   // shorthand for the response fields
   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign rsp_fields   = {rsp_status, rsp_data_length, rsp_decoded_checksum,
                          rsp_computed_checksum};
   assign figures_zero = (rsp_data_length == 8'd0) && (rsp_decoded_checksum == 8'd0) &&
                         (rsp_computed_checksum == 8'd0);
   assign sums_equal   = (rsp_decoded_checksum == rsp_computed_checksum);
   assign length_set   = (rsp_data_length != 8'd0);

   // a stalled response stays and holds its fields
   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_fields))

   // no response right after reset
   `ASSERT_ALWAYS(a_rsp_after_reset, clock, $past(reset), !rsp_valid)

   // a frame without comma reports all zero figures
   `ASSERT_IMP(a_no_comma_zero, clock, reset, rsp_valid && rsp_status == STATUS_NO_COMMA, figures_zero)

   // accepted means nonempty data and matching checksums
   `ASSERT_IMP(a_ok_consistent, clock, reset, rsp_valid && rsp_status == STATUS_OK, length_set && sums_equal)

   // mismatch means nonempty data and differing checksums
   `ASSERT_IMP(a_mismatch_consistent, clock, reset, rsp_valid && rsp_status == STATUS_MISMATCH, length_set && !sums_equal)

endmodule

bind framed_command_receiver_crc8_core fcr_checker u_fcr_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_if.valid),
   .rsp_ready             (rsp_if.ready),
   .rsp_status            (rsp_if.status),
   .rsp_data_length       (rsp_if.data_length),
   .rsp_decoded_checksum  (rsp_if.decoded_checksum),
   .rsp_computed_checksum (rsp_if.computed_checksum)
);

// ===== tb/fcr_tb_pkg.sv =====
package fcr_tb_pkg;
   import fcr_pkg::*;

   // one report as it leaves the block
   typedef struct packed {
      status_type status;
      logic [7:0] command_byte;
      logic [7:0] data_length;
      logic [7:0] decoded_checksum;
      logic [7:0] computed_checksum;
   } frame_report_type;

   // crc-8 msb first, one data bit into the feedback per step
   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] acc;
      logic       feedback;
      acc = crc;
      for (int i = 7; i >= 0; i--) begin
         feedback = acc[7] ^ data[i];
         acc = {acc[6:0], 1'b0} ^ (feedback ? CRC_POLY : 8'h00);
      end
      return acc;
   endfunction

   class frame_scoreboard;
      logic [15:0]      timeout_limit;
      bit               frame_open;
      int unsigned      body_count;
      logic [7:0]       crc_run;
      logic [7:0]       crc_at_comma;
      int unsigned      comma_at;
      bit               comma_found;
      logic [7:0]       number_acc;
      phase_type        number_state;
      bit               number_minus;
      logic [7:0]       lead_byte;
      int unsigned      ticks_open;
      frame_report_type expected_reports[$];
      int unsigned      mismatches;

      function new();
         timeout_limit = TIMEOUT_RESET;
         frame_open    = 1'b0;
         body_count    = 0;
         crc_run       = 8'h00;
         crc_at_comma  = 8'h00;
         comma_at      = 0;
         comma_found   = 1'b0;
         number_acc    = 8'h00;
         number_state  = PHASE_SKIP;
         number_minus  = 1'b0;
         lead_byte     = 8'h00;
         ticks_open    = 0;
         mismatches    = 0;
      endfunction

      task report_mismatch(input string what);
         mismatches++;
         $display("%0t mismatch: %s", $realtime, what);
      endtask

      // atoi-style decoding of the text after the last comma
      function void decode_checksum_char(input logic [7:0] b);
         bit blank;
         blank = (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
         if (number_state == PHASE_SKIP && blank) begin
            return;
         end
         if (number_state == PHASE_SKIP && (b == CHAR_PLUS || b == CHAR_MINUS)) begin
            number_minus = (b == CHAR_MINUS);
            number_state = PHASE_DIGITS;
            return;
         end
         if (number_state != PHASE_DONE && b >= CHAR_ZERO && b <= CHAR_NINE) begin
            number_acc   = 8'(int'(number_acc) * 10 + int'(b - CHAR_ZERO));
            number_state = PHASE_DIGITS;
            return;
         end
         number_state = PHASE_DONE;
      endfunction

      // advance the frame state by one accepted transfer
      function void absorb_item(input logic item_kind, input logic [7:0] b);
         frame_report_type r;
         if (item_kind == KIND_TICK && frame_open && ticks_open < ELAPSED_MAX) begin
            ticks_open++;
         end
         if (frame_open && ticks_open > timeout_limit) begin
            frame_open = 1'b0;
            body_count = 0;
         end
         if (item_kind == KIND_TICK) begin
            return;
         end
         if (b == CHAR_OPEN) begin
            frame_open   = 1'b1;
            body_count   = 0;
            crc_run      = 8'h00;
            crc_at_comma = 8'h00;
            comma_at     = 0;
            comma_found  = 1'b0;
            number_acc   = 8'h00;
            number_state = PHASE_SKIP;
            number_minus = 1'b0;
            lead_byte    = 8'h00;
            ticks_open   = 0;
            return;
         end
         if (b == CHAR_CLOSE) begin
            if (!frame_open) begin
               return;
            end
            frame_open          = 1'b0;
            r.status            = STATUS_NO_COMMA;
            r.command_byte      = lead_byte;
            r.data_length       = 8'h00;
            r.decoded_checksum  = 8'h00;
            r.computed_checksum = 8'h00;
            if (comma_found) begin
               r.data_length       = 8'(comma_at);
               r.computed_checksum = crc_at_comma;
               r.decoded_checksum  = number_minus ? 8'(0 - number_acc) : number_acc;
               if (comma_at == 0) begin
                  r.status = STATUS_EMPTY;
               end else if (r.decoded_checksum != r.computed_checksum) begin
                  r.status = STATUS_MISMATCH;
               end else begin
                  r.status = STATUS_OK;
               end
            end
            expected_reports.push_back(r);
            return;
         end
         if (!frame_open) begin
            return;
         end
         // body full: the frame and this byte are lost
         if (body_count >= FRAME_CAPACITY - 1) begin
            frame_open = 1'b0;
            body_count = 0;
            return;
         end
         if (body_count == 0) begin
            lead_byte = b;
         end
         if (b == CHAR_COMMA) begin
            crc_at_comma = crc_run;
            comma_at     = body_count;
            comma_found  = 1'b1;
            number_acc   = 8'h00;
            number_state = PHASE_SKIP;
            number_minus = 1'b0;
         end else if (comma_found) begin
            decode_checksum_char(b);
         end
         crc_run = crc8_next(crc_run, b);
         body_count++;
      endfunction

      task compare_field(input string label, input logic [7:0] got,
                         input logic [7:0] want);
         if (got !== want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", label, got, want));
         end
      endtask

      // compare a response transfer with the oldest expected report
      task check_report(input frame_report_type got);
         frame_report_type want;
         if (expected_reports.size() == 0) begin
            report_mismatch("response transfer with no frame report pending");
            return;
         end
         want = expected_reports.pop_front();
         compare_field("status", 8'(got.status), 8'(want.status));
         compare_field("command_byte", got.command_byte, want.command_byte);
         compare_field("data_length", got.data_length, want.data_length);
         compare_field("decoded_checksum", got.decoded_checksum, want.decoded_checksum);
         compare_field("computed_checksum", got.computed_checksum, want.computed_checksum);
      endtask

      task check_drained();
         if (expected_reports.size() != 0) begin
            report_mismatch($sformatf("%0d frame reports never arrived",
                                      expected_reports.size()));
         end
      endtask
   endclass

endpackage

// ===== tb/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import fcr_pkg::*;
   import fcr_tb_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_ITEMS = 175;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [15:0] csr_write_data;

   fcr_req_if req_bus ();
   fcr_rsp_if rsp_bus ();

   framed_command_receiver_crc8_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   frame_scoreboard frames;
   logic [7:0]      frame_text[$];
   logic [15:0]     timeout_now;
   bit              idle_on;
   int unsigned     items_sent;
   int unsigned     stalled_cycles = 0;
   int unsigned     ready_hold;

   // clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // response side: ready with random stall bursts
   initial begin
      ready_hold    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (ready_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            ready_hold--;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            ready_hold = $urandom_range(0, 3);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : response_monitor
      frame_report_type seen;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         seen.status            = rsp_bus.status;
         seen.command_byte      = rsp_bus.command_byte;
         seen.data_length       = rsp_bus.data_length;
         seen.decoded_checksum  = rsp_bus.decoded_checksum;
         seen.computed_checksum = rsp_bus.computed_checksum;
         frames.check_report(seen);
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
         if (stalled_cycles >= STALL_LIMIT) begin
            $display("watchdog expired after %0d cycles without a transfer", stalled_cycles);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // one request transfer, with an optional gap ahead of it
   task automatic send_item(input logic item_kind, input logic [7:0] item_byte);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.kind    <= item_kind;
      req_bus.rx_byte <= item_byte;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      frames.absorb_item(item_kind, item_byte);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(KIND_BYTE, b);
   endtask

   // the byte lane carries junk on a tick
   task automatic send_tick();
      send_item(KIND_TICK, 8'($urandom));
   endtask

   // write timeout_ms once the pipeline has drained
   task automatic write_timeout(input logic [15:0] value);
      req_bus.valid <= 1'b0;
      while (frames.expected_reports.size() != 0) @(posedge clock);
      repeat (6) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      timeout_now         = value;
      frames.timeout_limit = value;
   endtask

   function automatic logic [7:0] random_body_byte(input bit allow_comma);
      logic [7:0] b;
      do b = 8'($urandom);
      while (b == CHAR_OPEN || b == CHAR_CLOSE || (!allow_comma && b == CHAR_COMMA));
      return b;
   endfunction

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         frame_text.push_back(s[i]);
      end
   endfunction

   // body text: data, comma, then a checksum field in one of several spellings
   function automatic void build_payload(input int unsigned body_bytes);
      logic [7:0]  sum;
      int unsigned pick;
      sum = 8'h00;
      frame_text.delete();
      repeat (body_bytes) begin
         frame_text.push_back(($urandom_range(0, 9) == 0) ? CHAR_COMMA : random_body_byte(0));
         sum = crc8_next(sum, frame_text[$]);
      end
      frame_text.push_back(CHAR_COMMA);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         push_text($sformatf("%0d", sum));
      end else if (pick < 55) begin
         // leading white space, optional plus and a leading zero
         repeat ($urandom_range(1, 3)) begin
            frame_text.push_back($urandom_range(0, 1) ? CHAR_SPACE :
                                 8'($urandom_range(CHAR_TAB, CHAR_CR)));
         end
         if ($urandom_range(0, 1)) begin
            frame_text.push_back(CHAR_PLUS);
         end
         push_text($sformatf("0%0d", sum));
      end else if (pick < 65) begin
         frame_text.push_back(CHAR_MINUS);
         push_text($sformatf("%0d", (256 - int'(sum)) % 256));
      end else if (pick < 75) begin
         push_text($sformatf("%0d", $urandom_range(0, 99999)));
      end else if (pick < 83) begin
         // correct value with trailing junk after it
         push_text($sformatf("%0d", sum));
         repeat ($urandom_range(1, 3)) frame_text.push_back(random_body_byte(1));
      end else if (pick < 91) begin
         repeat ($urandom_range(1, 4)) frame_text.push_back(random_body_byte(1));
      end else begin
         // value past 255 that wraps onto the crc
         push_text($sformatf("%0d", int'(sum) + 256 * int'($urandom_range(1, 3))));
      end
   endfunction

   task automatic send_frame(input int unsigned tick_pct);
      send_byte(CHAR_OPEN);
      foreach (frame_text[i]) begin
         if ($urandom_range(0, 99) < tick_pct) begin
            send_tick();
         end
         send_byte(frame_text[i]);
      end
      send_byte(CHAR_CLOSE);
   endtask

   // frame that sits for a given number of ticks after its first byte
   task automatic send_held_frame(input int unsigned hold);
      build_payload($urandom_range(1, 6));
      send_byte(CHAR_OPEN);
      send_byte(frame_text[0]);
      repeat (hold) send_tick();
      for (int i = 1; i < frame_text.size(); i++) begin
         send_byte(frame_text[i]);
      end
      send_byte(CHAR_CLOSE);
   endtask

   // mostly well-formed frames, with noise, restarts, timeouts and overflows mixed in
   task automatic run_random_phase(input int unsigned quota);
      int unsigned start_count;
      int unsigned pick;
      start_count = items_sent;
      while (items_sent - start_count < quota) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            build_payload($urandom_range(1, 12));
            send_frame(8);
         end else if (pick < 78) begin
            frame_text.delete();
            repeat ($urandom_range(0, 8)) frame_text.push_back(random_body_byte(0));
            send_frame(8);
         end else if (pick < 83) begin
            build_payload(0);
            send_frame(8);
         end else if (pick < 88) begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 2) == 0) begin
                  send_tick();
               end else begin
                  send_byte(8'($urandom));
               end
            end
         end else if (pick < 92) begin
            send_byte(CHAR_OPEN);
            repeat ($urandom_range(1, 4)) send_byte(random_body_byte(1));
            build_payload($urandom_range(1, 8));
            send_frame(0);
         end else if (pick < 95 && timeout_now < 16'd300) begin
            send_held_frame(int'(timeout_now) + $urandom_range(0, 1));
         end else if (pick < 97) begin
            build_payload($urandom_range(100, 148));
            send_frame(2);
         end else begin
            frame_text.delete();
            repeat ($urandom_range(150, 160)) frame_text.push_back(random_body_byte(1));
            send_frame(0);
         end
      end
   endtask

   // stimulus
   initial begin
      frames           = new();
      timeout_now      = TIMEOUT_RESET;
      idle_on          = 1'b0;
      items_sent       = 0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = 16'h0000;
      req_bus.valid    = 1'b0;
      req_bus.kind     = KIND_BYTE;
      req_bus.rx_byte  = 8'h00;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset   <= 1'b0;
      idle_on = 1'b1;

      // outside a frame: tick, stray close, plain byte
      send_tick();
      send_byte(CHAR_CLOSE);
      send_byte(8'h78);
      // empty body
      send_byte(CHAR_OPEN);
      send_byte(CHAR_CLOSE);
      // nothing ahead of the comma
      frame_text = {CHAR_COMMA, 8'h35};
      send_frame(0);
      // zero byte in the body, matching checksum
      frame_text = {8'h00, CHAR_COMMA, CHAR_ZERO};
      send_frame(0);
      // restart mid-frame, then a negative checksum that misses
      send_byte(CHAR_OPEN);
      send_byte(8'h41);
      frame_text = {8'hFF, CHAR_COMMA, CHAR_MINUS, 8'h33};
      send_frame(0);
      // no comma, with a tick inside
      send_byte(CHAR_OPEN);
      send_byte(8'h5A);
      send_tick();
      send_byte(CHAR_CLOSE);

      // longest body that still fits, comma in the last slot
      frame_text.delete();
      repeat (FRAME_CAPACITY - 2) frame_text.push_back(random_body_byte(0));
      frame_text.push_back(CHAR_COMMA);
      send_frame(0);
      // one byte past capacity
      frame_text.delete();
      repeat (FRAME_CAPACITY) frame_text.push_back(random_body_byte(1));
      send_frame(0);
      // timeout boundary at the reset value
      send_held_frame(int'(TIMEOUT_RESET));
      send_held_frame(int'(TIMEOUT_RESET) + 1);

      // shortest timeout
      write_timeout(16'd1);
      send_held_frame(1);
      send_held_frame(2);
      run_random_phase(PHASE_ITEMS);

      // longest timeout
      write_timeout(16'hFFFF);
      run_random_phase(PHASE_ITEMS);

      write_timeout(16'($urandom_range(2, 60)));
      run_random_phase(PHASE_ITEMS);

      write_timeout(16'($urandom_range(61, 65534)));
      run_random_phase(PHASE_ITEMS);

      // last stretch at full rate on both sides
      idle_on = 1'b0;
      write_timeout(TIMEOUT_RESET);
      run_random_phase(PHASE_ITEMS);

      req_bus.valid <= 1'b0;
      while (frames.expected_reports.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      frames.check_drained();
      if (frames.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== framed_command_receiver_crc8_core.f =====
+incdir+rtl
rtl/fcr_pkg.sv
rtl/fcr_req_if.sv
rtl/fcr_rsp_if.sv
rtl/framed_command_receiver_crc8_core.sv
rtl/fcr_checker.sv
tb/fcr_tb_pkg.sv
tb/testbench.sv
